/* sv/iprm_pkg.sv */
package iprm_pkg;

	localparam int RULES = 64;
	localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int CNT_W = $clog2(RULES + 1);

	localparam int ADDR_W = 32;
	localparam int LEN_W = 6;
	localparam int REQ_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [LEN_W-1:0] MAX_PREFIX = 6'd32;

	typedef struct packed {
		logic load;
		logic latch;
		logic write;
		logic clear;
		logic rd_first;
		logic rd_next;
		logic compare;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic len_bad;
		logic full;
		logic empty;
		logic scan_end;
	} sts_t;

	function automatic logic [ADDR_W-1:0] prefix_to_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		m = '0;
		if (len != '0) begin
			m = ALL_ONES << (MAX_PREFIX - len);
		end
		return m;
	endfunction

endpackage

/* sv/iprm_ctrl.sv */
module iprm_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  iprm_pkg::sts_t sts,
	output iprm_pkg::cmd_t cmd,
	output logic busy,
	output logic done
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.latch = 1'b1;
				state_d = ST_RESP;
				if (sts.req == iprm_pkg::REQ_ADD) begin
					cmd.write = !sts.len_bad && !sts.full;
				end else if (sts.req == iprm_pkg::REQ_CLEAR) begin
					cmd.clear = 1'b1;
				end else if (sts.req == iprm_pkg::REQ_LOOKUP && !sts.empty) begin
					cmd.rd_first = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.compare = 1'b1;
				if (sts.scan_end) begin
					state_d = ST_RESP;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_EXEC))
		else $error("accepted beat did not enter execution");

	a_resp_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.scan_end) |=> done)
		else $error("scan end did not lead to a result");

endmodule

/* sv/iprm_dp.sv */
module iprm_dp (
	input  logic clk,
	input  logic arst_n,
	input  iprm_pkg::cmd_t cmd,
	input  logic [iprm_pkg::REQ_W-1:0] req_type,
	input  logic [iprm_pkg::ADDR_W-1:0] address,
	input  logic [iprm_pkg::LEN_W-1:0] pfx_len,
	output iprm_pkg::sts_t sts,
	output logic hit,
	output logic [iprm_pkg::STATUS_W-1:0] status
);

	logic [2*iprm_pkg::ADDR_W-1:0] mem [iprm_pkg::RULES];

	logic [iprm_pkg::REQ_W-1:0] req_q;
	logic [iprm_pkg::ADDR_W-1:0] addr_q;
	logic [iprm_pkg::LEN_W-1:0] len_q;
	logic [iprm_pkg::CNT_W-1:0] count_q;
	logic [iprm_pkg::IDX_W-1:0] rd_idx_q;
	logic [2*iprm_pkg::ADDR_W-1:0] rd_data_q;
	logic hit_q;
	logic [iprm_pkg::STATUS_W-1:0] status_q;

	logic [iprm_pkg::IDX_W-1:0] rd_addr;
	logic [iprm_pkg::ADDR_W-1:0] new_mask;
	logic match;
	logic last;
	logic [iprm_pkg::STATUS_W-1:0] status_d;

	function automatic logic [iprm_pkg::ADDR_W-1:0] address_masked(
		input logic [iprm_pkg::ADDR_W-1:0] a,
		input logic [iprm_pkg::ADDR_W-1:0] m
	);
		return a & m;
	endfunction

	assign new_mask = iprm_pkg::prefix_to_mask(len_q);
	assign rd_addr = cmd.rd_first ? '0 : rd_idx_q + 1'b1;
	assign match = (addr_q & rd_data_q[2*iprm_pkg::ADDR_W-1:iprm_pkg::ADDR_W])
		== rd_data_q[iprm_pkg::ADDR_W-1:0];
	assign last = (iprm_pkg::CNT_W'(rd_idx_q) + 1'b1) == count_q;

	always_comb begin
		status_d = iprm_pkg::ST_OK;
		if (req_q == iprm_pkg::REQ_ADD) begin
			if (sts.len_bad) begin
				status_d = iprm_pkg::ST_BAD_LEN;
			end else if (sts.full) begin
				status_d = iprm_pkg::ST_FULL;
			end
		end
	end

	assign sts.req = req_q;
	assign sts.len_bad = (len_q > iprm_pkg::MAX_PREFIX);
	assign sts.full = (count_q == iprm_pkg::CNT_W'(iprm_pkg::RULES));
	assign sts.empty = (count_q == '0);
	assign sts.scan_end = match || last;

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[count_q[iprm_pkg::IDX_W-1:0]] <= {new_mask, address_masked(addr_q, new_mask)};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_first || cmd.rd_next) begin
			rd_data_q <= mem[rd_addr];
			rd_idx_q <= rd_addr;
		end
		if (cmd.load) begin
			req_q <= req_type;
			addr_q <= address;
			len_q <= pfx_len;
		end
		if (cmd.latch) begin
			status_q <= status_d;
			hit_q <= 1'b0;
		end else if (cmd.compare) begin
			hit_q <= match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.write) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign hit = hit_q;
	assign status = status_q;

endmodule

/* sv/ipv4_prefix_rule_matcher.sv */
// Keeps up to RULES IPv4 prefix rules and answers add, lookup and clear requests, one result
// beat per request on hit and status, marked by a one-cycle done strobe; the receiver cannot
// stall, so each beat must be taken in the cycle in which done is high. A request is taken
// when start is high and busy is low. For add, clear and unknown requests, and for a lookup
// on an empty table, the request passes through the EXEC and RESP states, done is high in RESP and busy
// stays high through that cycle, so the next request can be taken once busy falls after the result
// beat. A lookup reads the rule memory through its single read port, one rule per cycle in
// insertion order, in the SCAN state between EXEC and RESP, and stops at the first match or
// after the last stored rule.
module ipv4_prefix_rule_matcher (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [iprm_pkg::REQ_W-1:0] req_type,
	input  logic [iprm_pkg::ADDR_W-1:0] address,
	input  logic [iprm_pkg::LEN_W-1:0] pfx_len,
	output logic done,
	output logic hit,
	output logic [iprm_pkg::STATUS_W-1:0] status
);

	iprm_pkg::cmd_t cmd;
	iprm_pkg::sts_t sts;

	iprm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.sts(sts),
		.cmd(cmd),
		.busy(busy),
		.done(done)
	);

	iprm_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req_type(req_type),
		.address(address),
		.pfx_len(pfx_len),
		.sts(sts),
		.hit(hit),
		.status(status)
	);

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

	localparam logic [iprm_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 400;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = iprm_pkg::RULES + 16;

	typedef struct packed {
		logic hit;
		logic [iprm_pkg::STATUS_W-1:0] status;
	} reply_t;

	class rule_table_scoreboard;
		logic [iprm_pkg::ADDR_W-1:0] rule_net[iprm_pkg::RULES];
		logic [iprm_pkg::ADDR_W-1:0] rule_msk[iprm_pkg::RULES];
		int rule_cnt;
		reply_t pending_replies[$];
		int mismatches;

		function logic [iprm_pkg::ADDR_W-1:0] len_mask(input logic [iprm_pkg::LEN_W-1:0] len);
			return ~(iprm_pkg::ALL_ONES >> len);
		endfunction

		function void note_request(input logic [iprm_pkg::REQ_W-1:0] req,
				input logic [iprm_pkg::ADDR_W-1:0] addr,
				input logic [iprm_pkg::LEN_W-1:0] len);
			reply_t r;
			r = '0;
			case (req)
				iprm_pkg::REQ_ADD: begin
					if (len > iprm_pkg::MAX_PREFIX) begin
						r.status = iprm_pkg::ST_BAD_LEN;
					end else if (rule_cnt >= iprm_pkg::RULES) begin
						r.status = iprm_pkg::ST_FULL;
					end else begin
						rule_msk[rule_cnt] = len_mask(len);
						rule_net[rule_cnt] = addr & len_mask(len);
						rule_cnt++;
					end
				end
				iprm_pkg::REQ_LOOKUP: begin
					for (int k = 0; k < rule_cnt; k++) begin
						if ((addr & rule_msk[k]) == rule_net[k]) begin
							r.hit = 1'b1;
						end
					end
				end
				iprm_pkg::REQ_CLEAR: begin
					rule_cnt = 0;
				end
				default: begin
				end
			endcase
			pending_replies = {pending_replies, r};
		endfunction

		function void check_reply(input logic hit, input logic [iprm_pkg::STATUS_W-1:0] status);
			reply_t want;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result beat with no request pending: hit %0b status %0d",
						$time, hit, status);
				end
				return;
			end
			want = pending_replies.pop_front();
			if (hit !== want.hit || status !== want.status) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: expected hit %0b status %0d, got hit %0b status %0d",
						$time, want.hit, want.status, hit, status);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [iprm_pkg::REQ_W-1:0] req_type = '0;
	logic [iprm_pkg::ADDR_W-1:0] address = '0;
	logic [iprm_pkg::LEN_W-1:0] pfx_len = '0;
	logic done;
	logic hit;
	logic [iprm_pkg::STATUS_W-1:0] status;

	rule_table_scoreboard sb;
	int n_items = 0;
	int stall_cycles = 0;
	bit no_gaps = 1'b0;

	ipv4_prefix_rule_matcher i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.address(address),
		.pfx_len(pfx_len),
		.done(done),
		.hit(hit),
		.status(status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic idle_gap();
		int n;
		n = 0;
		if (!no_gaps) begin
			case ($urandom_range(0, 9))
				0, 1, 2: n = $urandom_range(1, 3);
				3: n = $urandom_range(8, 40);
				default: n = 0;
			endcase
		end
		if (n > 0) begin
			start = 1'b0;
			repeat (n) begin
				address = $urandom;
				@(negedge clk);
			end
		end
	endtask

	task automatic send_request(input logic [iprm_pkg::REQ_W-1:0] r,
			input logic [iprm_pkg::ADDR_W-1:0] a, input logic [iprm_pkg::LEN_W-1:0] l);
		start = 1'b1;
		req_type = r;
		address = a;
		pfx_len = l;
		do @(posedge clk); while (busy);
		sb.note_request(r, a, l);
		if (r != REQ_UNUSED) begin
			n_items++;
		end
		@(negedge clk);
		idle_gap();
	endtask

	function automatic logic [iprm_pkg::LEN_W-1:0] rand_len();
		return iprm_pkg::LEN_W'($urandom);
	endfunction

	function automatic logic [iprm_pkg::LEN_W-1:0] pick_len();
		case ($urandom_range(0, 39))
			0, 1, 2: return iprm_pkg::LEN_W'($urandom_range(33, 63));
			3: return '0;
			4, 5: return iprm_pkg::MAX_PREFIX;
			6: return 6'd1;
			default: return iprm_pkg::LEN_W'($urandom_range(8, 31));
		endcase
	endfunction

	// Keys mostly fall inside a stored rule, sometimes one bit off it, else anywhere.
	function automatic logic [iprm_pkg::ADDR_W-1:0] pick_key();
		int k;
		logic [iprm_pkg::ADDR_W-1:0] key;
		if (sb.rule_cnt == 0 || $urandom_range(0, 9) < 3) begin
			return $urandom;
		end
		k = $urandom_range(0, sb.rule_cnt - 1);
		key = sb.rule_net[k] | ($urandom & ~sb.rule_msk[k]);
		if ($urandom_range(0, 3) == 0) begin
			key ^= 32'h1 << $urandom_range(0, 31);
		end
		return key;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_reply(hit, status);
		end
	end

	initial begin
		do begin
			@(posedge clk);
			if (!arst_n || done || (start && !busy)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end while (stall_cycles < STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int n_adds;
		int n_keys;
		sb = new;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(iprm_pkg::REQ_LOOKUP, $urandom, rand_len());
		send_request(iprm_pkg::REQ_ADD, $urandom, 6'd33);
		send_request(iprm_pkg::REQ_ADD, $urandom, 6'd63);
		send_request(iprm_pkg::REQ_ADD, iprm_pkg::ALL_ONES, 6'd0);
		send_request(iprm_pkg::REQ_LOOKUP, 32'h1234_5678, rand_len());
		send_request(REQ_UNUSED, $urandom, rand_len());
		send_request(iprm_pkg::REQ_CLEAR, $urandom, rand_len());
		send_request(iprm_pkg::REQ_LOOKUP, 32'h0000_0000, rand_len());
		send_request(iprm_pkg::REQ_ADD, 32'hC0A8_01FF, iprm_pkg::MAX_PREFIX);
		send_request(iprm_pkg::REQ_LOOKUP, 32'hC0A8_01FF, rand_len());
		send_request(iprm_pkg::REQ_LOOKUP, 32'hC0A8_01FE, rand_len());
		send_request(iprm_pkg::REQ_ADD, 32'h8123_4567, 6'd1);
		send_request(iprm_pkg::REQ_LOOKUP, iprm_pkg::ALL_ONES, rand_len());
		send_request(iprm_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, rand_len());
		send_request(iprm_pkg::REQ_ADD, 32'h0A12_3456, 6'd8);
		send_request(iprm_pkg::REQ_LOOKUP, 32'h0AFF_FFFF, rand_len());
		send_request(iprm_pkg::REQ_LOOKUP, 32'h0000_0000, rand_len());
		send_request(iprm_pkg::REQ_CLEAR, $urandom, rand_len());
		send_request(iprm_pkg::REQ_LOOKUP, 32'hC0A8_01FF, rand_len());

		// Send RULES + 4 adds once, one of them with length 40, to push towards a full table and a bad length.
		send_request(iprm_pkg::REQ_CLEAR, $urandom, rand_len());
		for (int i = 0; i < iprm_pkg::RULES + 4; i++) begin
			send_request(iprm_pkg::REQ_ADD, $urandom,
				(i == iprm_pkg::RULES + 1) ? 6'd40 : pick_len());
		end
		for (int i = 0; i < 20; i++) begin
			send_request(iprm_pkg::REQ_LOOKUP, pick_key(), rand_len());
		end

		while (n_items < ITEM_TARGET) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0) begin
				send_request(iprm_pkg::REQ_CLEAR, $urandom, rand_len());
			end
			n_adds = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10);
			for (int i = 0; i < n_adds; i++) begin
				send_request(iprm_pkg::REQ_ADD, $urandom, pick_len());
			end
			n_keys = $urandom_range(3, 15);
			for (int i = 0; i < n_keys; i++) begin
				case ($urandom_range(0, 19))
					0: send_request(REQ_UNUSED, $urandom, rand_len());
					1: send_request(iprm_pkg::REQ_ADD, $urandom, pick_len());
					default: send_request(iprm_pkg::REQ_LOOKUP, pick_key(), rand_len());
				endcase
			end
		end

		start = 1'b0;
		while (sb.pending_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
